>>> hw/rtl/kcv3_pkg.sv
// shared constants, types and helpers for the three-axis kalman unit
package kcv3_pkg;

	localparam int AXES_DEF = 3;
	localparam int AW = 24;
	localparam int VW = 32;
	localparam int PW = 32;

	localparam logic [15:0] DT_RST = 16'd1092;
	localparam logic [31:0] QA_RST = 32'd655;
	localparam logic [31:0] QV_RST = 32'd6554;
	localparam logic [31:0] R_RST = 32'd32768;
	localparam logic [31:0] PI_RST = 32'd65536;

	localparam logic [2:0] REG_DT = 3'd0;
	localparam logic [2:0] REG_QA = 3'd1;
	localparam logic [2:0] REG_QV = 3'd2;
	localparam logic [2:0] REG_R = 3'd3;
	localparam logic [2:0] REG_PI = 3'd4;

	// per-axis filter state
	typedef struct packed {
		logic signed [AW-1:0] ang;
		logic signed [VW-1:0] vel;
		logic [PW-1:0] p00;
		logic [PW-1:0] p01;
		logic [PW-1:0] p11;
	} axis_st_t;

	// register file view handed to the axis engine
	typedef struct packed {
		logic [15:0] dt;
		logic [31:0] qa;
		logic [31:0] qv;
		logic [31:0] r;
	} cfg_t;

	function automatic logic [31:0] sat_u32(input logic [33:0] x);
		sat_u32 = (x[33:32] != 2'b00) ? 32'hFFFF_FFFF : x[31:0];
	endfunction

	// round(x / 2^16), ties toward +infinity
	function automatic logic signed [63:0] rnd16(input logic signed [63:0] x);
		logic signed [63:0] y;
		y = x + 64'sd32768;
		rnd16 = y >>> 16;
	endfunction

	function automatic logic signed [AW-1:0] sat_ang(input logic signed [63:0] x);
		if (x > 64'sd8388607) sat_ang = 24'sh7FFFFF;
		else if (x < -64'sd8388608) sat_ang = 24'sh800000;
		else sat_ang = x[AW-1:0];
	endfunction

	function automatic logic signed [VW-1:0] sat_vel(input logic signed [63:0] x);
		if (x > 64'sd2147483647) sat_vel = 32'sh7FFFFFFF;
		else if (x < -64'sd2147483648) sat_vel = 32'sh80000000;
		else sat_vel = x[VW-1:0];
	endfunction

endpackage

>>> hw/rtl/kcv3_axis.sv
// one-axis predict/correct engine on a shared multiplier and a radix-2 divider
module kcv3_axis (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  kcv3_pkg::cfg_t cfg,
	input  kcv3_pkg::axis_st_t st_in,
	input  logic signed [23:0] z,
	output kcv3_pkg::axis_st_t st_out,
	output logic done
);
	import kcv3_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_XP   = 5'd1;
	localparam logic [4:0] S_P01  = 5'd2;
	localparam logic [4:0] S_P00A = 5'd3;
	localparam logic [4:0] S_P00B = 5'd4;
	localparam logic [4:0] S_DIV0 = 5'd5;
	localparam logic [4:0] S_DV0  = 5'd6;
	localparam logic [4:0] S_DIV1 = 5'd7;
	localparam logic [4:0] S_DV1  = 5'd8;
	localparam logic [4:0] S_ANG  = 5'd9;
	localparam logic [4:0] S_VEL  = 5'd10;
	localparam logic [4:0] S_C00  = 5'd11;
	localparam logic [4:0] S_C01  = 5'd12;
	localparam logic [4:0] S_C11  = 5'd13;
	localparam logic [4:0] S_DONE = 5'd14;

	logic [4:0] state_q;
	logic [5:0] cnt_q;
	logic signed [AW-1:0] xp_q, ang_q;
	logic signed [VW-1:0] vel_q;
	logic [PW-1:0] p01p_q, p00p_q, p11p_q, p00_q, p01_q, p11_q;
	logic [16:0] k0_q;
	logic [31:0] k1_q;
	logic [32:0] s_q;
	logic [48:0] num_q, quo_q;
	logic [33:0] rem_q;
	logic signed [25:0] e_q;

	// shared multiplier: 34x34 signed operands
	logic signed [33:0] ma, mb;
	logic signed [67:0] mp;
	assign mp = ma * mb;

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			S_XP: begin ma = {18'd0, cfg.dt}; mb = {{2{st_in.vel[31]}}, st_in.vel}; end
			S_P01: begin ma = {18'd0, cfg.dt}; mb = {2'b0, st_in.p11}; end
			S_P00A: begin ma = {18'd0, cfg.dt}; mb = {2'b0, st_in.p01}; end
			S_P00B: begin ma = {18'd0, cfg.dt}; mb = {2'b0, p01p_q}; end
			S_ANG: begin ma = {17'd0, k0_q}; mb = {{8{e_q[25]}}, e_q}; end
			S_VEL: begin ma = {2'b0, k1_q}; mb = {{8{e_q[25]}}, e_q}; end
			S_C00: begin ma = {17'd0, 17'h10000 - k0_q}; mb = {2'b0, p00p_q}; end
			S_C01: begin ma = {17'd0, 17'h10000 - k0_q}; mb = {2'b0, p01p_q}; end
			S_C11: begin ma = {2'b0, k1_q}; mb = {2'b0, p01p_q}; end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	logic [34:0] rem_sh;
	logic [34:0] rem_sub;
	assign rem_sh = {rem_q, num_q[48]};
	assign rem_sub = rem_sh - {2'b0, s_q};

	logic [33:0] acc;
	logic [47:0] red;
	logic signed [63:0] mp64;
	assign mp64 = 64'(mp);
	assign acc = {2'b0, p00p_q} + {2'b0, mp[47:16]};
	assign red = mp[63:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_XP;
				S_XP: state_q <= S_P01;
				S_P01: state_q <= S_P00A;
				S_P00A: state_q <= S_P00B;
				S_P00B: state_q <= S_DIV0;
				S_DIV0: begin state_q <= S_DV0; cnt_q <= '0; end
				S_DV0: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd48) state_q <= S_DIV1;
				end
				S_DIV1: begin state_q <= S_DV1; cnt_q <= '0; end
				S_DV1: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd48) state_q <= S_ANG;
				end
				S_ANG: state_q <= S_VEL;
				S_VEL: state_q <= S_C00;
				S_C00: state_q <= S_C01;
				S_C01: state_q <= S_C11;
				S_C11: state_q <= S_DONE;
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_XP: begin
				xp_q <= sat_ang(64'(st_in.ang) + rnd16(mp64));
				p11p_q <= sat_u32({2'b0, st_in.p11} + {2'b0, cfg.qv});
			end
			S_P01: p01p_q <= sat_u32({2'b0, st_in.p01} + {2'b0, mp[47:16]});
			S_P00A: p00p_q <= sat_u32({2'b0, st_in.p00} + {2'b0, mp[47:16]}
				+ {2'b0, cfg.qa});
			S_P00B: begin
				p00p_q <= sat_u32(acc);
				e_q <= 26'(z) - 26'(xp_q);
			end
			S_DIV0: begin
				s_q <= {1'b0, p00p_q} + {1'b0, cfg.r};
				num_q <= {1'b0, p00p_q, 16'd0};
				rem_q <= '0;
				quo_q <= '0;
			end
			S_DV0, S_DV1: begin
				if (s_q != 33'd0 && !rem_sub[34]) begin
					rem_q <= rem_sub[33:0];
					quo_q <= {quo_q[47:0], 1'b1};
				end else begin
					rem_q <= rem_sh[33:0];
					quo_q <= {quo_q[47:0], 1'b0};
				end
				num_q <= {num_q[47:0], 1'b0};
			end
			S_DIV1: begin
				k0_q <= (s_q == 33'd0) ? 17'd0 : quo_q[16:0];
				num_q <= {1'b0, p01p_q, 16'd0};
				rem_q <= '0;
				quo_q <= '0;
			end
			S_ANG: begin
				k1_q <= (s_q == 33'd0) ? 32'd0 :
					((quo_q[48:32] != 17'd0) ? 32'hFFFF_FFFF : quo_q[31:0]);
				ang_q <= sat_ang(64'(xp_q) + rnd16(mp64));
			end
			S_VEL: vel_q <= sat_vel(64'(st_in.vel) + rnd16(mp64));
			S_C00: p00_q <= mp[47:16];
			S_C01: p01_q <= mp[47:16];
			S_C11: p11_q <= (red >= {16'd0, p11p_q}) ? 32'd0 : p11p_q - red[31:0];
			default: ;
		endcase
	end

	assign done = (state_q == S_DONE);
	assign st_out = '{ang: ang_q, vel: vel_q, p00: p00_q, p01: p01_q, p11: p11_q};

	ap_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	ap_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && state_q == S_IDLE) |=> state_q == S_XP) else $error("start lost");
	ap_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DV0 || state_q == S_DV1) |-> cnt_q <= 6'd48) else $error("div overrun");
endmodule

>>> hw/rtl/kalman_constant_velocity_3axis_unit.sv
// top level: apb registers, per-axis state, stream handshake and axis sequencing
//
// Three-axis constant-velocity Kalman smoother for pitch, yaw and roll.
// Input word on s_axis: tdata = {roll, yaw, pitch} Q12.12, tuser = restart.
// Output word on m_axis: tdata = filtered {roll, yaw, pitch}, tuser = passed_raw.
// One result word per input word, in order.
// Registers on the APB port: 0x00 dt, 0x04 q angle, 0x08 q velocity,
// 0x0C r, 0x10 p initial; write only while idle.
// An initializing word (first after reset, or restart) loads the state and
// goes through T_OUT into the output register without running the engine.
// A filtered word runs each axis in turn through one shared multiplier and a
// one-bit-per-cycle divider (two 49-step divides); after the last axis the
// result goes through T_OUT into the output register. In both cases the next
// word is taken only once the result has left the output register.
// s_axis_tready is high only when idle and the output register is empty.
// Reset clears the filter state and loads register defaults.
// A stalled m_axis holds the result; no new word is taken until it leaves.
module kalman_constant_velocity_3axis_unit #(
	parameter int AXES = kcv3_pkg::AXES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [71:0] s_axis_tdata,   // pitch_in, yaw_in, roll_in
	input  logic s_axis_tuser,          // restart
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [71:0] m_axis_tdata,   // pitch_out, yaw_out, roll_out
	output logic m_axis_tuser,          // passed_raw
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [4:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import kcv3_pkg::*;

	localparam int IW = (AXES > 1) ? $clog2(AXES) : 1;
	localparam logic [1:0] T_IDLE = 2'd0;
	localparam logic [1:0] T_RUN  = 2'd1;
	localparam logic [1:0] T_OUT  = 2'd2;

	logic [15:0] dt_q;
	logic [31:0] qa_q, qv_q, r_q, pi_q;
	logic [1:0] tstate_q;
	logic [IW-1:0] ax_q;
	logic primed_q, go_q, raw_q, ovalid_q;
	logic [71:0] z_q, odata_q;
	axis_st_t st_q [AXES];
	axis_st_t st_new;
	logic eng_done;
	logic signed [23:0] z_sel;
	cfg_t cfg;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= DT_RST; qa_q <= QA_RST; qv_q <= QV_RST; r_q <= R_RST; pi_q <= PI_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[4:2])
				REG_DT: dt_q <= pwdata[15:0];
				REG_QA: qa_q <= pwdata;
				REG_QV: qv_q <= pwdata;
				REG_R: r_q <= pwdata;
				REG_PI: pi_q <= pwdata;
				default: ;
			endcase
		end
	end
	always_comb begin
		unique case (paddr[4:2])
			REG_DT: prdata = {16'd0, dt_q};
			REG_QA: prdata = qa_q;
			REG_QV: prdata = qv_q;
			REG_R: prdata = r_q;
			REG_PI: prdata = pi_q;
			default: prdata = '0;
		endcase
	end

	assign cfg = '{dt: dt_q, qa: qa_q, qv: qv_q, r: r_q};

	always_comb begin
		z_sel = '0;
		for (int i = 0; i < 3; i++)
			if (32'(ax_q) == i) z_sel = z_q[24*i +: 24];
	end

	kcv3_axis u_axis (
		.clk(clk), .arst_n(arst_n), .start(go_q), .cfg(cfg),
		.st_in(st_q[ax_q]), .z(z_sel), .st_out(st_new), .done(eng_done)
	);

	assign s_axis_tready = (tstate_q == T_IDLE) && !ovalid_q;
	wire take = s_axis_tvalid && s_axis_tready;
	wire init = !primed_q || s_axis_tuser;
	wire last_ax = (32'(ax_q) == AXES - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tstate_q <= T_IDLE;
			primed_q <= 1'b0;
			go_q <= 1'b0;
			ovalid_q <= 1'b0;
			ax_q <= '0;
			for (int i = 0; i < AXES; i++) st_q[i] <= '0;
		end else begin
			go_q <= 1'b0;
			if (m_axis_tvalid && m_axis_tready) ovalid_q <= 1'b0;
			unique case (tstate_q)
				T_IDLE: if (take) begin
					z_q <= s_axis_tdata;
					raw_q <= init;
					primed_q <= 1'b1;
					ax_q <= '0;
					if (init) begin
						for (int i = 0; i < AXES; i++)
							st_q[i] <= '{ang: (i < 3) ? s_axis_tdata[24*(i%3) +: 24] : 24'd0,
								vel: '0, p00: pi_q, p01: '0, p11: pi_q};
						tstate_q <= T_OUT;
					end else begin
						go_q <= 1'b1;
						tstate_q <= T_RUN;
					end
				end
				T_RUN: if (eng_done) begin
					st_q[ax_q] <= st_new;
					if (last_ax) tstate_q <= T_OUT;
					else begin
						ax_q <= ax_q + IW'(1);
						go_q <= 1'b1;
					end
				end
				T_OUT: begin
					ovalid_q <= 1'b1;
					tstate_q <= T_IDLE;
				end
				default: tstate_q <= T_IDLE;
			endcase
		end
	end

	always_comb begin
		odata_q = '0;
		for (int i = 0; i < 3; i++)
			if (i < AXES) odata_q[24*i +: 24] = st_q[i%AXES].ang;
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = odata_q;
	assign m_axis_tuser = raw_q;

	ap_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(tstate_q != T_IDLE) |-> !s_axis_tready) else $error("ready while busy");
	ap_out_after: assert property (@(posedge clk) disable iff (!arst_n)
		(tstate_q == T_OUT) |=> ovalid_q) else $error("result lost");
	ap_primed: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q |-> primed_q) else $error("output unprimed");
endmodule

>>> tb/kcv3_checker.sv
// checker: watches the stream and register ports, predicts the filter outputs and compares
`timescale 1ns / 100ps

module kcv3_checker
	import kcv3_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	input  logic s_axis_tready,
	input  logic [71:0] s_axis_tdata,
	input  logic s_axis_tuser,
	input  logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  logic [71:0] m_axis_tdata,
	input  logic m_axis_tuser,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [4:0] paddr,
	input  logic [31:0] pwdata,
	input  logic pready,
	output int errors,
	output int pending,
	output int checked
);

	typedef struct packed {
		logic signed [23:0] roll;
		logic signed [23:0] yaw;
		logic signed [23:0] pitch;
		logic raw;
	} pose_t;

	pose_t pose_q[$];

	logic [15:0] dt;
	logic [31:0] qa, qv, rn, pinit;
	logic primed;
	logic signed [23:0] ang[3];
	logic signed [31:0] vel[3];
	logic [31:0] p00[3], p01[3], p11[3];

	assign pending = pose_q.size();

	task automatic report(input string what, input longint got, input longint want);
		errors++;
		if (errors <= 20)
			$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
	endtask

	function automatic longint rnd_shift(input longint x);
		longint y;
		y = x + 64'sd32768;
		return y >>> 16;
	endfunction

	function automatic longint clamp(input longint x, input longint lo, input longint hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	function automatic logic [31:0] usat(input logic [63:0] x);
		return x > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : x[31:0];
	endfunction

	task automatic smooth_axis(input int a, input longint z);
		longint xp, e, dtl;
		logic [63:0] p01p, p00p, p11p, s, k0, k1, red, dtu;
		dtu = {48'b0, dt};
		dtl = longint'(dtu);
		xp = clamp(longint'(ang[a]) + rnd_shift(dtl * longint'(vel[a])), -8388608, 8388607);
		p01p = {32'b0, usat({32'b0, p01[a]} + ((dtu * {32'b0, p11[a]}) >> 16))};
		p00p = {32'b0, usat({32'b0, p00[a]} + ((dtu * {32'b0, p01[a]}) >> 16)
			+ ((dtu * p01p) >> 16) + {32'b0, qa})};
		p11p = {32'b0, usat({32'b0, p11[a]} + {32'b0, qv})};
		s = p00p + {32'b0, rn};
		if (s == 0) begin
			k0 = '0;
			k1 = '0;
		end else begin
			k0 = (p00p << 16) / s;
			k1 = {32'b0, usat((p01p << 16) / s)};
		end
		e = z - xp;
		ang[a] = 24'(clamp(xp + rnd_shift(longint'(k0) * e), -8388608, 8388607));
		vel[a] = 32'(clamp(longint'(vel[a]) + rnd_shift(longint'(k1) * e),
			-64'sd2147483648, 64'sd2147483647));
		p00[a] = 32'(((64'd65536 - k0) * p00p) >> 16);
		p01[a] = 32'(((64'd65536 - k0) * p01p) >> 16);
		red = (k1 * p01p) >> 16;
		p11[a] = red >= p11p ? 32'd0 : p11p[31:0] - red[31:0];
	endtask

	task automatic predict_pose(input logic [71:0] meas, input logic restart);
		pose_t r;
		logic init;
		longint z;
		init = !primed || restart;
		for (int a = 0; a < 3; a++) begin
			z = longint'($signed(meas[24*a +: 24]));
			if (init) begin
				ang[a] = 24'(z);
				vel[a] = '0;
				p00[a] = pinit;
				p01[a] = '0;
				p11[a] = pinit;
			end else begin
				smooth_axis(a, z);
			end
		end
		primed = 1'b1;
		r.pitch = ang[0];
		r.yaw = ang[1];
		r.roll = ang[2];
		r.raw = init;
		pose_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		pose_t w;
		if (!arst_n) begin
			dt = DT_RST;
			qa = QA_RST;
			qv = QV_RST;
			rn = R_RST;
			pinit = PI_RST;
			primed = 1'b0;
			for (int a = 0; a < 3; a++) begin
				ang[a] = '0;
				vel[a] = '0;
				p00[a] = '0;
				p01[a] = '0;
				p11[a] = '0;
			end
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_DT: dt = pwdata[15:0];
					REG_QA: qa = pwdata;
					REG_QV: qv = pwdata;
					REG_R: rn = pwdata;
					REG_PI: pinit = pwdata;
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				checked++;
				if (pose_q.size() == 0) begin
					report("unexpected word, tuser", m_axis_tuser, 0);
				end else begin
					w = pose_q.pop_front();
					if ($signed(m_axis_tdata[23:0]) !== w.pitch)
						report("pitch_out", $signed(m_axis_tdata[23:0]), w.pitch);
					if ($signed(m_axis_tdata[47:24]) !== w.yaw)
						report("yaw_out", $signed(m_axis_tdata[47:24]), w.yaw);
					if ($signed(m_axis_tdata[71:48]) !== w.roll)
						report("roll_out", $signed(m_axis_tdata[71:48]), w.roll);
					if (m_axis_tuser !== w.raw)
						report("passed_raw", m_axis_tuser, w.raw);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_pose(s_axis_tdata, s_axis_tuser);
		end
	end

	initial begin
		errors = 0;
		checked = 0;
	end

endmodule

>>> tb/testbench.sv
// testbench top: clock, reset, stimulus, register phases and verdict
`timescale 1ns / 100ps

module testbench;
	import kcv3_pkg::*;

	localparam longint CYCLE_LIMIT = 4000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;
	logic m_axis_tuser;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	int errors, pending, checked;
	int burst_left = 0;
	int restarts = 0;
	int settings = 0;
	bit long_hold = 0;
	longint cycles = 0;
	logic signed [23:0] track[3];

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	kalman_constant_velocity_3axis_unit u_top (.*);

	kcv3_checker u_check (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("kalman_constant_velocity_3axis_unit test failed");
			$finish;
		end
	end

	// receiver stall pattern, picks a new character after each random span
	initial begin
		int mode, span;
		mode = 0;
		span = 0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				m_axis_tready <= 1'b0;
				repeat (3000) @(posedge clk);
				long_hold = 0;
			end
			if (span == 0) begin
				mode = $urandom_range(0, 2);
				span = $urandom_range(50, 400);
			end
			span--;
			case (mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= $urandom_range(0, 1);
				default: m_axis_tready <= ($urandom_range(0, 9) == 0);
			endcase
		end
	end

	task automatic send_word(input logic signed [23:0] p, input logic signed [23:0] y,
			input logic signed [23:0] r, input logic restart);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 3) != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 500)) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {r, y, p};
		s_axis_tuser <= restart;
		if (restart)
			restarts++;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_regs(input logic [15:0] d, input logic [31:0] a, input logic [31:0] v,
			input logic [31:0] r, input logic [31:0] pi);
		reg_write(REG_DT, {16'b0, d});
		reg_write(REG_QA, a);
		reg_write(REG_QV, v);
		reg_write(REG_R, r);
		reg_write(REG_PI, pi);
		settings++;
	endtask

	function automatic logic signed [23:0] pick_angle(input int ax);
		int sel;
		sel = $urandom_range(0, 19);
		if (sel == 0)
			return 24'($urandom());
		if (sel == 1)
			return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
		// smooth trajectory with noise, the usual head pose shape
		track[ax] = track[ax] + $signed(24'($urandom_range(0, 800))) - 24'sd400;
		return track[ax] + $signed(24'($urandom_range(0, 200))) - 24'sd100;
	endfunction

	task automatic random_words(input int n);
		for (int i = 0; i < n; i++) begin
			if (i == n / 2 && !long_hold && settings == 4)
				long_hold = 1;
			send_word(pick_angle(0), pick_angle(1), pick_angle(2), $urandom_range(0, 39) == 0);
		end
	endtask

	initial begin
		for (int a = 0; a < 3; a++)
			track[a] = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes and restart under default registers
		send_word(24'sh7FFFFF, 24'sh800000, 24'sd0, 1'b0);
		send_word(24'sh800000, 24'sh7FFFFF, -24'sd1, 1'b0);
		send_word(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
		send_word(24'sd4096, -24'sd4096, 24'sd1, 1'b1);
		send_word(24'sd8192, -24'sd8192, 24'sd2, 1'b0);
		send_word(24'sh555555, 24'shAAAAAA, 24'sh0F0F0F, 1'b0);
		drain();
		// zero innovation variance: no noise, zero covariance, zero r
		set_regs(16'hFFFF, 32'd0, 32'd0, 32'd0, 32'd0);
		send_word(24'sd100, 24'sd200, 24'sd300, 1'b1);
		send_word(24'sd900, -24'sd900, 24'sh7FFFFF, 1'b0);
		send_word(24'sd5, 24'sd6, 24'sd7, 1'b0);
		drain();
		// saturating covariances and a large step
		set_regs(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
		send_word(24'sh800000, 24'sh7FFFFF, 24'sd0, 1'b1);
		send_word(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 1'b0);
		send_word(24'sh800000, 24'sh7FFFFF, 24'sh800000, 1'b0);
		send_word(24'sd0, 24'sd0, 24'sd0, 1'b0);
		drain();
		// huge measurement noise, zero step
		set_regs(16'd0, 32'd1, 32'd1, 32'hFFFF_FFFF, 32'd1);
		send_word(24'sd0, 24'sd1, -24'sd1, 1'b1);
		send_word(24'sh7FFFFF, 24'sh800000, 24'sd12345, 1'b0);
		drain();

		// random phases, each under its own register setting
		set_regs(DT_RST, QA_RST, QV_RST, R_RST, PI_RST);
		random_words(400);
		drain();
		set_regs(16'd65535, 32'd100, 32'd40000, 32'd65536, 32'd1 << 20);
		random_words(300);
		drain();
		for (int ph = 0; ph < 4; ph++) begin
			set_regs(16'($urandom()), $urandom_range(0, 32'h0010_0000), $urandom(),
				$urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 32'h0004_0000),
				$urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'h0010_0000));
			random_words(250);
			drain();
		end

		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		$display("checked %0d output words over %0d register settings, %0d restart words",
			checked, settings, restarts);
		if (errors == 0)
			$display("kalman_constant_velocity_3axis_unit test passed");
		else
			$display("kalman_constant_velocity_3axis_unit test failed");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/kcv3_pkg.sv
hw/rtl/kcv3_axis.sv
hw/rtl/kalman_constant_velocity_3axis_unit.sv
tb/kcv3_checker.sv
tb/testbench.sv
